### design/rgb_to_cie_xy_assert.svh
// ----------------------------------------------------------------------------
// rgb_to_cie_xy assertion macros
// shared assertion forms for the colour pipeline
// ----------------------------------------------------------------------------
`ifndef RGB_TO_CIE_XY_ASSERT_SVH
`define RGB_TO_CIE_XY_ASSERT_SVH

// checked outside reset
`define RCX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked through reset as well
`define RCX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rcx_pkg.sv
// ----------------------------------------------------------------------------
// rcx_pkg
// constants, curve table and pipeline word type for rgb_to_cie_xy
// ----------------------------------------------------------------------------
`default_nettype none

package rcx_pkg;

  localparam int CHROMA_SCALE_BITS = 16;
  localparam int QBITS = CHROMA_SCALE_BITS + 1;
  localparam int LIN_W = 17;
  localparam int COEF_W = 16;
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int SUM_W = 34;
  localparam int REM_W = SUM_W + QBITS + 1;
  localparam int OUT_W = 16;

  localparam longint LIM_RAW = (64'd1 << CHROMA_SCALE_BITS) - 64'd2;
  localparam logic [OUT_W-1:0] LIM = (LIM_RAW > 64'd65534) ? 16'd65534 : OUT_W'(LIM_RAW);

  typedef logic [COEF_W-1:0] coef_row_t [3];
  typedef coef_row_t coef_mat_t [3];
  localparam coef_mat_t COEF = '{
    '{16'd27027, 16'd23436, 16'd11829},
    '{16'd13933, 16'd46871, 16'd4732},
    '{16'd1265,  16'd7812,  16'd62292}
  };

  typedef logic [LIN_W-1:0] lin_tab_t [256];

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    logic [63:0] cv, t, s, lo, hi, mid, r2, r4, p, l;
    for (int c = 0; c < 256; c++) begin
      cv = 64'(c);
      if (c <= 10) begin
        tab[c] = LIN_W'((cv * 64'd655360 + 64'd16473) / 64'd32946);
      end else begin
        t = ((cv * 64'd1000 + 64'd14025) << 30) / 64'd269025;
        s = (t * t) >> 30;
        lo = 64'd0;
        hi = 64'd1 << 30;
        for (int k = 0; k < 32; k++) begin
          if (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            r2 = (mid * mid) >> 30;
            r4 = (r2 * r2) >> 30;
            p = (r4 * mid) >> 30;
            if (p <= s) lo = mid;
            else hi = mid - 64'd1;
          end
        end
        l = (s * lo) >> 30;
        tab[c] = LIN_W'((l + (64'd1 << 13)) >> 14);
      end
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [REM_W-1:0] rem_x;
    logic [REM_W-1:0] rem_y;
    logic [REM_W-1:0] dsh;
    logic [QBITS-1:0] q_x;
    logic [QBITS-1:0] q_y;
  } div_word_t;

endpackage

`default_nettype wire

### design/rgb_to_cie_xy.sv
// ----------------------------------------------------------------------------
// rgb_to_cie_xy
// srgb byte triple to cie 1931 xy chromaticity
// ----------------------------------------------------------------------------
// input channel rgb_valid/rgb_ready carries one word of red, green, blue.
// output channel xy_valid/xy_ready carries chroma_x and chroma_y, each the
// chromaticity times 65536, rounded and clamped to 0..65534; black gives 0, 0.
// one word is taken every cycle unless the output stalls; from acceptance to
// xy_valid it passes curve lookup, products, matrix sums, dividend set-up, then a
// chain of 17 division cells, one quotient bit each, and the output register.
// the whole pipeline moves together; it stalls only while a result sits in
// the output register and xy_ready is low, so rgb_ready is low exactly then.
// reset empties every stage; no result appears until a word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_cie_xy
  import rcx_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              rgb_valid,
  output logic                   rgb_ready,
  input  wire logic [7:0]        red,
  input  wire logic [7:0]        green,
  input  wire logic [7:0]        blue,
  output logic                   xy_valid,
  input  wire logic              xy_ready,
  output logic [OUT_W-1:0]       chroma_x,
  output logic [OUT_W-1:0]       chroma_y
);

  logic adv;
  assign adv = !xy_valid || xy_ready;
  assign rgb_ready = adv;

  logic             v0, v1, v2;
  logic [LIN_W-1:0] lin [3];
  logic [PROD_W-1:0] prod [3][3];
  logic [SUM_W-1:0] xyz [3];

  div_word_t chain [QBITS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (adv) begin
      v0 <= rgb_valid;
      lin[0] <= LIN_TAB[red];
      lin[1] <= LIN_TAB[green];
      lin[2] <= LIN_TAB[blue];
      v1 <= v0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= PROD_W'(lin[j]) * PROD_W'(COEF[i][j]);
        end
      end
      v2 <= v1;
      for (int i = 0; i < 3; i++) begin
        xyz[i] <= SUM_W'(prod[i][0]) + SUM_W'(prod[i][1]) + SUM_W'(prod[i][2]);
      end
    end
  end

  // dividend set-up: (part << qbits) + total over total << qbits
  logic [SUM_W-1:0] total;
  assign total = xyz[0] + xyz[1] + xyz[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].valid <= 1'b0;
    end else if (adv) begin
      chain[0].valid <= v2;
      chain[0].zero <= (total == '0);
      chain[0].rem_x <= (REM_W'(xyz[0]) << QBITS) + REM_W'(total);
      chain[0].rem_y <= (REM_W'(xyz[1]) << QBITS) + REM_W'(total);
      chain[0].dsh <= REM_W'(total) << QBITS;
      chain[0].q_x <= '0;
      chain[0].q_y <= '0;
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    rcx_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (adv),
      .d_in  (chain[k]),
      .d_out (chain[k+1])
    );
  end

  div_word_t last;
  assign last = chain[QBITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      xy_valid <= 1'b0;
    end else if (adv) begin
      xy_valid <= last.valid;
      if (last.zero) begin
        chroma_x <= '0;
        chroma_y <= '0;
      end else begin
        chroma_x <= (last.q_x > QBITS'(LIM)) ? LIM : OUT_W'(last.q_x);
        chroma_y <= (last.q_y > QBITS'(LIM)) ? LIM : OUT_W'(last.q_y);
      end
    end
  end

`include "rgb_to_cie_xy_assert.svh"

  `RCX_ASSERT(a_clamp, xy_valid |-> (chroma_x <= LIM && chroma_y <= LIM), "result above clamp")
  `RCX_ASSERT(a_sum, xy_valid |-> (17'(chroma_x) + 17'(chroma_y) <= 17'd65537), "x plus y above one")
  `RCX_ASSERT_RST(a_rst, rst |=> !xy_valid, "result right after reset")

endmodule

`default_nettype wire

### design/rcx_cell.sv
// ----------------------------------------------------------------------------
// rcx_cell
// one quotient bit of the x and y division, registered
// ----------------------------------------------------------------------------
`default_nettype none

module rcx_cell
  import rcx_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire div_word_t d_in,
  output div_word_t      d_out
);

  logic ge_x, ge_y;
  div_word_t w_next;

  always_comb begin
    ge_x = d_in.rem_x >= d_in.dsh;
    ge_y = d_in.rem_y >= d_in.dsh;
    w_next = d_in;
    w_next.rem_x = ge_x ? d_in.rem_x - d_in.dsh : d_in.rem_x;
    w_next.rem_y = ge_y ? d_in.rem_y - d_in.dsh : d_in.rem_y;
    w_next.dsh = d_in.dsh >> 1;
    w_next.q_x = {d_in.q_x[QBITS-2:0], ge_x};
    w_next.q_y = {d_in.q_y[QBITS-2:0], ge_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_out.valid <= 1'b0;
    end else if (en) begin
      d_out <= w_next;
    end
  end

endmodule

`default_nettype wire
